// ===== hdl/lrd_pkg.sv =====
// Package for the LFSR hashed random draw block: sequencer states, opcodes,
// hash constants and the mix function. No dependencies.
package lrd_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned ModW  = 31;

    localparam logic [31:0] LfsrTaps  = 32'ha300_0000;
    localparam logic [31:0] PreScale  = 32'd71;
    localparam logic [31:0] HashMulK  = 32'd15731;
    localparam logic [31:0] HashAddA  = 32'd789221;
    localparam logic [31:0] HashAddB  = 32'd1376312589;
    localparam logic [31:0] Mask31    = 32'h7fff_ffff;

    typedef enum logic {
        OP_SEED = 1'b0,
        OP_DRAW = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M71,
        S_MIX1,
        S_VV,
        S_VK,
        S_ADD,
        S_VS,
        S_FIN1,
        S_FIN2,
        S_CHK,
        S_DIV,
        S_DONE
    } t_fsm;

    // x = ((x << 13) ^ x) - (x >>> 21), wrapping at 32 bits
    function automatic logic [31:0] hash_mix(input logic [31:0] x);
        logic [31:0] sh;
        sh = 32'($signed(x) >>> 21);
        return ((x << 13) ^ x) - sh;
    endfunction

endpackage

// ===== hdl/lrd_mul.sv =====
// Shared 32x32 multiplier, low 32 bits of the product, registered output.
// Depends on lrd_pkg.
module lrd_mul (
    input  logic                     i_clk,
    input  logic [lrd_pkg::DataW-1:0] i_a,
    input  logic [lrd_pkg::DataW-1:0] i_b,
    output logic [lrd_pkg::DataW-1:0] o_p
);
    import lrd_pkg::*;

    logic [DataW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hdl/lrd_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on lrd_pkg.
module lrd_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [lrd_pkg::ModW-1:0] i_dividend,
    input  logic [lrd_pkg::ModW-1:0] i_divisor,
    output logic                     o_done,
    output logic [lrd_pkg::ModW-1:0] o_rem
);
    import lrd_pkg::*;

    localparam int unsigned CntW = $clog2(ModW);
    localparam logic [CntW-1:0] LastCnt = CntW'(ModW - 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [ModW-1:0] r_dvd;
    logic [ModW-1:0] r_dsr;
    logic [ModW-1:0] r_rem;
    logic [ModW:0]   w_trial;
    logic [ModW:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[ModW-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LastCnt);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastCnt) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            // keep the difference when it did not borrow
            r_rem <= w_diff[ModW] ? w_trial[ModW-1:0] : w_diff[ModW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/lfsr_hashed_random_draw_top.sv =====
// Top level of the LFSR hashed random draw block: sequencer, state registers
// and output register. Depends on lrd_pkg, lrd_mul and lrd_div.
//
// Usage:
//   Input stream (s_axis): tuser carries the opcode (0 = load seed, 1 = draw),
//   tdata carries seed_value in bits 31:0 and draw_range in bits 63:32.
//   A load-seed word writes the 32-bit generator state (zero is stored as 1);
//   it gives no output word.
//   A draw word steps the Galois LFSR, hashes the new state through the
//   shared multiplier (four products), then reduces modulo draw_range when it
//   is positive through the bit-serial remainder unit.
//   Output stream (m_axis): tdata carries random_value, one word per draw.
//   The four multiplies of a draw run in turn through the one shared
//   multiplier; the 31-step remainder loop follows when the modulo applies.
//   The block takes one word at a time; s_axis_tready is high only while the
//   sequencer is idle.
//   The output register holds a finished word while m_axis_tready is low; the
//   input side still accepts the next word, and a later draw waits in its
//   last step until the register is free.
//   Reset (synchronous, active low) clears the state to zero (unseeded) and
//   drops the output valid; a draw from the unseeded state uses state 1.
module lfsr_hashed_random_draw_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] seed_value, [63:32] draw_range
    input  logic [0:0]  i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] random_value
);
    import lrd_pkg::*;

    t_fsm              r_fsm, n_fsm;
    logic [DataW-1:0]  r_state, n_state;
    logic [DataW-1:0]  r_v, n_v;
    logic [DataW-1:0]  r_t, n_t;
    logic [DataW-1:0]  r_range, n_range;
    logic              r_out_valid, n_out_valid;
    logic [DataW-1:0]  r_out_data, n_out_data;

    logic [DataW-1:0]  w_mul_a, w_mul_b, w_prod;
    logic              w_div_start, w_div_done;
    logic [ModW-1:0]   w_rem;
    logic              w_accept;
    logic              w_range_pos;
    logic [DataW-1:0]  w_seed, w_cur, w_step;

    assign o_s_axis_tready = (r_fsm == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_seed          = i_s_axis_tdata[31:0];
    assign w_range_pos     = !r_range[DataW-1] && (r_range != '0);

    // Galois step of the current state; an unseeded state counts as 1
    assign w_cur  = (r_state == '0) ? 32'd1 : r_state;
    assign w_step = w_cur[0] ? ((w_cur >> 1) ^ LfsrTaps) : (w_cur >> 1);

    lrd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    lrd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_t[ModW-1:0]),
        .i_divisor  (r_range[ModW-1:0]),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_t        <= n_t;
        r_range    <= n_range;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_fsm       = r_fsm;
        n_state     = r_state;
        n_v         = r_v;
        n_t         = r_t;
        n_range     = r_range;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        w_mul_a     = r_v;
        w_mul_b     = r_v;
        w_div_start = 1'b0;
        case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    if (t_opcode'(i_s_axis_tuser[0]) == OP_SEED) begin
                        n_state = (w_seed == '0) ? 32'd1 : w_seed;
                    end else begin
                        n_state = w_step;
                        n_range = i_s_axis_tdata[63:32];
                        n_fsm   = S_M71;
                    end
                end
            end
            S_M71: begin
                w_mul_a = r_state;
                w_mul_b = PreScale;
                n_fsm   = S_MIX1;
            end
            S_MIX1: begin
                n_v   = hash_mix(w_prod);
                n_fsm = S_VV;
            end
            S_VV: begin
                n_fsm = S_VK;          // v * v
            end
            S_VK: begin
                w_mul_a = w_prod;
                w_mul_b = HashMulK;
                n_fsm   = S_ADD;
            end
            S_ADD: begin
                n_t   = w_prod + HashAddA;
                n_fsm = S_VS;
            end
            S_VS: begin
                w_mul_a = r_v;
                w_mul_b = r_t;
                n_fsm   = S_FIN1;
            end
            S_FIN1: begin
                n_t   = ((w_prod + HashAddB) & Mask31) + r_v;
                n_fsm = S_FIN2;
            end
            S_FIN2: begin
                n_t   = hash_mix(r_t);
                n_fsm = S_CHK;
            end
            S_CHK: begin
                if (w_range_pos) begin
                    w_div_start = 1'b1;
                    n_fsm       = S_DIV;
                end else begin
                    n_fsm = S_DONE;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_t   = {1'b0, w_rem};
                    n_fsm = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_t;
                    n_fsm       = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a reduced draw never reaches or exceeds its modulus
    a_mod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DONE && w_range_pos) |-> (r_t < r_range))
        else $error("reduced draw out of range");

    // the remainder unit only reports back while the sequencer waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_fsm == S_DIV))
        else $error("remainder done outside wait state");

    // once a word is accepted the generator state is never left at zero
    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != '0))
        else $error("generator state zero after accept");

    // a pending output word is only replaced once it has been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DONE && r_out_valid && !i_m_axis_tready) |=> $stable(r_out_data))
        else $error("output word overwritten while stalled");
`endif

endmodule

// ===== verif/tb_lfsr_hashed_random_draw_top.sv =====
// Testbench for lfsr_hashed_random_draw_top: a directed table, then random seed/draw
// words, each draw checked against a built-in copy of the LFSR step, hash and modulo or a typed-in value.
// Depends on lrd_pkg (opcodes, hash constants) and the RTL of the block.
`timescale 1ns / 100ps

module tb_lfsr_hashed_random_draw_top;
    import lrd_pkg::*;

    localparam int RandWords    = 1030;
    localparam int IdlePct      = 19;
    localparam int HoldCycles   = 300;
    localparam int DrainCycles  = 80;
    localparam int CycleLimit   = 600000;
    localparam int PrintLimit   = 40;

    // clock, reset and ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // [31:0] seed_value, [63:32] draw_range
    logic [0:0]  i_s_axis_tuser;   // [0] opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] random_value

    lfsr_hashed_random_draw_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    typedef struct {
        t_opcode     op;
        logic [31:0] seed;
        logic [31:0] range;
        bit          has_lit;   // expected value typed in below
        logic [31:0] lit;
    } t_stim_row;

    t_stim_row   directed_rows[$];
    logic [31:0] pending_draws[$];   // expected random_value, oldest first
    logic [31:0] gen_state;          // predicted LFSR state
    int          mismatch_cnt;
    int          cycle_cnt;
    bit          calm;               // no idling on either side
    bit          hold_req;           // ask the receiver for a long hold-off

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // ((x << 13) ^ x) - (x >>> 21), sign fill spelled out
    function automatic logic [31:0] shuffle_word(logic [31:0] x);
        logic [31:0] sar;
        sar = {{21{x[31]}}, x[31:21]};
        return ((x << 13) ^ x) - sar;
    endfunction

    function automatic logic [31:0] noise_of(logic [31:0] x);
        logic [31:0] v;
        logic [31:0] t;
        v = shuffle_word(x);
        t = (v * (v * v * HashMulK + HashAddA) + HashAddB) & Mask31;
        t = t + v;
        return shuffle_word(t);
    endfunction

    // advances gen_state and returns the drawn value
    function automatic logic [31:0] step_and_draw(logic [31:0] range);
        logic [31:0] h;
        if (gen_state == 32'd0)
            gen_state = 32'd1;   // unseeded state runs as 1
        if (gen_state[0])
            gen_state = (gen_state >> 1) ^ LfsrTaps;
        else
            gen_state = gen_state >> 1;
        h = noise_of(gen_state * PreScale);
        // non-positive range: raw hash
        if (!range[31] && range != 32'd0)
            h = (h & Mask31) % range;
        return h;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_cnt < PrintLimit)
            $display("MISMATCH @%0d: %s got %h want %h", cycle_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("unexpected word", o_m_axis_tdata, 32'd0);
            end else begin
                if (o_m_axis_tdata !== pending_draws[0])
                    report_mismatch("random_value", o_m_axis_tdata, pending_draws[0]);
                void'(pending_draws.pop_front());
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** lfsr_hashed_random_draw_top: FAILED **");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_m_axis_tready = calm || ($urandom_range(99) >= IdlePct);
        end
    end

    // ---------------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------------

    // entered and left at a falling edge; tvalid stays high between words
    // unless a gap is drawn
    task automatic send_word(t_stim_row row);
        logic [31:0] val;
        while (!calm && $urandom_range(99) < IdlePct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = row.op;
        i_s_axis_tdata  = {row.range, row.seed};
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        if (row.op == OP_SEED) begin
            gen_state = (row.seed == 32'd0) ? 32'd1 : row.seed;
        end else begin
            val = step_and_draw(row.range);
            pending_draws.push_back(row.has_lit ? row.lit : val);
        end
        @(negedge i_clk);
    endtask

    task automatic add_row(t_opcode op, logic [31:0] seed, logic [31:0] range,
                           bit has_lit = 1'b0, logic [31:0] lit = 32'd0);
        t_stim_row r;
        r.op      = op;
        r.seed    = seed;
        r.range   = range;
        r.has_lit = has_lit;
        r.lit     = lit;
        directed_rows.push_back(r);
    endtask

    function automatic t_stim_row random_row();
        t_stim_row   r;
        int          k;
        logic [31:0] w;
        r.has_lit = 1'b0;
        r.lit     = 32'd0;
        r.op      = ($urandom_range(99) < 25) ? OP_SEED : OP_DRAW;
        k = $urandom_range(99);
        if (k < 8)       r.seed = 32'd0;
        else if (k < 16) r.seed = 32'hffff_ffff;
        else             r.seed = $urandom;
        w = $urandom;
        k = $urandom_range(99);
        if (k < 10)      r.range = 32'd0;
        else if (k < 25) r.range = {1'b1, w[30:0]};
        else if (k < 30) r.range = w[0] ? 32'h8000_0000 : 32'hffff_ffff;
        else if (k < 55) r.range = $urandom_range(16, 1);
        else if (k < 70) r.range = 32'd1 << $urandom_range(30);
        else if (k < 75) r.range = 32'h7fff_ffff;
        else             r.range = {1'b0, w[30:0]};
        return r;
    endfunction

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        gen_state       = 32'd0;
        mismatch_cnt    = 0;
        cycle_cnt       = 0;
        calm            = 1'b0;
        hold_req        = 1'b0;

        // directed table; range 1 always reduces to zero
        add_row(OP_DRAW, 32'd0,         32'd0);          // draw before any seed
        add_row(OP_DRAW, 32'hffff_ffff, 32'd1, 1'b1, 32'd0);
        add_row(OP_SEED, 32'd0,         32'hffff_ffff);  // zero seed stored as 1
        add_row(OP_DRAW, 32'd0,         32'h7fff_ffff);
        add_row(OP_SEED, 32'hffff_ffff, 32'd0);
        add_row(OP_DRAW, 32'd0,         32'h8000_0000);  // most negative: raw
        add_row(OP_DRAW, 32'd0,         32'hffff_ffff);  // -1: raw
        add_row(OP_DRAW, 32'd0,         32'd1, 1'b1, 32'd0);
        add_row(OP_SEED, 32'd1,         32'd5);
        add_row(OP_DRAW, 32'd0,         32'd2);
        add_row(OP_SEED, 32'h8000_0000, 32'h8000_0000);
        add_row(OP_DRAW, 32'hffff_ffff, 32'd3);          // seed field ignored
        add_row(OP_SEED, LfsrTaps,      32'd7);
        add_row(OP_DRAW, 32'h1234_5678, 32'h7fff_ffff);
        add_row(OP_SEED, 32'h5555_5555, 32'h0);
        add_row(OP_DRAW, 32'haaaa_aaaa, 32'haaaa_aaaa);
        add_row(OP_DRAW, 32'h5555_5555, 32'h5555_5555);
        add_row(OP_SEED, 32'haaaa_aaaa, 32'h5555_5555);
        add_row(OP_DRAW, 32'd0,         32'h4000_0000);
        add_row(OP_SEED, 32'd0,         32'd0);
        add_row(OP_DRAW, 32'd0,         32'd1, 1'b1, 32'd0);
        add_row(OP_DRAW, 32'd0,         32'd0);
        add_row(OP_DRAW, 32'd0,         32'd16);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        for (int i = 0; i < RandWords; i++) begin
            calm = (i >= 400 && i < 550);
            if (i == 250)
                hold_req = 1'b1;   // output stalls, input backs up behind it
            if (i == 700) begin
                // pause until every draw so far has come out
                i_s_axis_tvalid = 1'b0;
                while (pending_draws.size() != 0) @(negedge i_clk);
            end
            send_word(random_row());
        end
        i_s_axis_tvalid = 1'b0;
        calm = 1'b0;

        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("** lfsr_hashed_random_draw_top: PASSED **");
        else
            $display("** lfsr_hashed_random_draw_top: FAILED **");
        $finish;
    end

endmodule
